FILE: rtl/core/rt_pkg.sv
// ----------------------------------------------------------------------------
// rt_pkg
// Shared types and constants of the IPv4 route table: command and status
// codes, the input and result words, one table entry and the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

package rt_pkg;

    // Default table depth and the number of interfaces a local route may use.
    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int DEVICE_COUNT      = 16;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    // Command codes of an input word; the fourth code is unused.
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_DELETE = 2'd2
    } route_cmd_t;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNREACH = 2'd1,
        ST_FULL    = 2'd2
    } route_status_t;

    // Bit positions in route_flags.
    localparam int FLAG_GW   = 0;
    localparam int FLAG_HOST = 1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [31:0] gateway_addr;
        logic [1:0]  route_flags;
        logic [3:0]  device_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_hop;
        logic [3:0]  out_device;
    } out_word_t;

    // One stored route; its valid bit lives apart so that reset clears it.
    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic        is_gw;
        logic [3:0]  device;
        logic        is_default;
    } route_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic capture;
        logic commit;
    } rt_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_COMMIT
    } rt_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rt_ctrl.sv
// ----------------------------------------------------------------------------
// rt_ctrl
// Controller of the route table: sequences each word through a compare state
// and a commit state and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rt_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output rt_pkg::rt_ctrl_t ctrl
);
    import rt_pkg::*;

    rt_state_t state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    logic      slot_free;

    // State and result flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register can take a new word when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load_item = 1'b1;
                    state_next     = S_MATCH;
                end
            end
            S_MATCH:
            begin
                ctrl.capture = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (slot_free)
                begin
                    ctrl.commit = 1'b1;
                    in_ready    = 1'b1;
                    if (in_valid)
                    begin
                        ctrl.load_item = 1'b1;
                        state_next     = S_MATCH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A commit fills the result register; a taken result empties it.
    always_comb
    begin
        if (ctrl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rt_datapath.sv
// ----------------------------------------------------------------------------
// rt_datapath
// Route storage and the per-entry compare lanes, the priority pick, the
// remove-and-append update of the packed table and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rt_datapath #(
    parameter int ROUTE_ENTRIES = rt_pkg::ROUTE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rt_pkg::rt_ctrl_t ctrl,
    input  wire rt_pkg::in_word_t in_word,
    output rt_pkg::out_word_t     out_word
);
    import rt_pkg::*;

    localparam int N = ROUTE_ENTRIES;
    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    in_word_t     item_reg;
    route_entry_t table_reg [N];
    route_entry_t table_next [N];
    logic [N-1:0] valid_reg, valid_next;
    logic [N-1:0] first_reg, exact_reg, dflt_reg;
    logic [N-1:0] first_cmp, exact_cmp, dflt_cmp;
    out_word_t    out_word_reg, out_word_next;

    logic [31:0]  match_addr;
    logic [N-1:0] first_oh, dflt_oh, sel_oh, exact_oh, ge_exact, ins_oh;
    logic         first_any, dflt_any, exact_any;
    route_entry_t sel_entry, new_entry;
    logic         is_add, is_delete, is_lookup;
    logic         add_fail, table_full, do_insert, do_remove;

    // Input word register, loaded on acceptance.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= in_word;
        end
    end

    // Compare lanes: a lookup matches the address, an add matches its gateway.
    assign match_addr = (item_reg.command == CMD_LOOKUP) ? item_reg.dest_addr
                                                         : item_reg.gateway_addr;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            first_cmp[i] = valid_reg[i] &&
                (((match_addr ^ table_reg[i].dest) & table_reg[i].mask) == 32'd0);
            exact_cmp[i] = valid_reg[i] && (table_reg[i].dest == item_reg.dest_addr);
            dflt_cmp[i]  = valid_reg[i] && table_reg[i].is_default;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            first_reg <= first_cmp;
            exact_reg <= exact_cmp;
            dflt_reg  <= dflt_cmp;
        end
    end

    // Priority pick: the lowest set bit of each match vector.
    assign first_oh  = first_reg & (~first_reg + ONE);
    assign dflt_oh   = dflt_reg & (~dflt_reg + ONE);
    assign exact_oh  = exact_reg & (~exact_reg + ONE);
    assign first_any = |first_reg;
    assign dflt_any  = |dflt_reg;
    assign exact_any = |exact_reg;
    assign sel_oh    = first_any ? first_oh : dflt_oh;

    // Read the picked entry through an AND-OR select.
    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < N; i++)
        begin
            sel_entry = sel_entry | (table_reg[i] & {$bits(route_entry_t){sel_oh[i]}});
        end
    end

    // Add and delete decisions.
    assign is_lookup  = (item_reg.command == CMD_LOOKUP);
    assign is_add     = (item_reg.command == CMD_ADD);
    assign is_delete  = (item_reg.command == CMD_DELETE);
    assign add_fail   = item_reg.route_flags[FLAG_GW] ? !first_any
                        : (int'(item_reg.device_index) >= DEVICE_COUNT);
    assign table_full = !exact_any && (&valid_reg);
    assign do_remove  = exact_any && (is_delete || (is_add && !add_fail));
    assign do_insert  = is_add && !add_fail && !table_full;

    // Entries at and above the removed one move down by one.
    assign ge_exact = ~(exact_oh - ONE);

    // The new route goes to the first free slot once the gap is closed.
    assign ins_oh = exact_any ? (valid_reg & ~(valid_reg >> 1))
                              : (~valid_reg & ((valid_reg << 1) | ONE));

    // The entry to append.
    always_comb
    begin
        new_entry.dest       = item_reg.dest_addr;
        new_entry.mask       = item_reg.route_flags[FLAG_HOST] ? ALL_ONES
                                                               : item_reg.net_mask;
        new_entry.gateway    = item_reg.gateway_addr;
        new_entry.is_gw      = item_reg.route_flags[FLAG_GW];
        new_entry.device     = item_reg.route_flags[FLAG_GW] ? sel_entry.device
                                                             : item_reg.device_index;
        new_entry.is_default = 1'b0;
        if (item_reg.dest_addr == 32'd0)
        begin
            new_entry.is_gw      = 1'b1;
            new_entry.is_default = 1'b1;
        end
    end

    // Next contents of each slot.
    for (genvar g = 0; g < N; g++)
    begin : g_slot
        route_entry_t upper_entry;
        logic         upper_valid;

        if (g < N - 1)
        begin : g_upper
            assign upper_entry = table_reg[g+1];
            assign upper_valid = valid_reg[g+1];
        end
        else
        begin : g_top
            assign upper_entry = '0;
            assign upper_valid = 1'b0;
        end

        always_comb
        begin
            table_next[g] = table_reg[g];
            valid_next[g] = valid_reg[g];
            if (do_remove && ge_exact[g])
            begin
                table_next[g] = upper_entry;
                valid_next[g] = upper_valid;
            end
            if (do_insert && (item_reg.dest_addr == 32'd0))
            begin
                table_next[g].is_default = 1'b0;
            end
            if (do_insert && ins_oh[g])
            begin
                table_next[g] = new_entry;
                valid_next[g] = 1'b1;
            end
        end
    end

    // Table storage; only the valid bits are reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            for (int i = 0; i < N; i++)
            begin
                table_reg[i] <= table_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            valid_reg <= valid_next;
        end
    end

    // Result word.
    always_comb
    begin
        out_word_next = '0;
        if (is_lookup)
        begin
            if (first_any || dflt_any)
            begin
                out_word_next.status     = ST_OK;
                out_word_next.next_hop   = sel_entry.is_gw ? sel_entry.gateway
                                                           : item_reg.dest_addr;
                out_word_next.out_device = sel_entry.device;
            end
            else
            begin
                out_word_next.status = ST_UNREACH;
            end
        end
        else if (is_add)
        begin
            if (add_fail)
            begin
                out_word_next.status = ST_UNREACH;
            end
            else if (table_full)
            begin
                out_word_next.status = ST_FULL;
            end
            else
            begin
                out_word_next.status = ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_word = out_word_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ip_route_table.sv
// ----------------------------------------------------------------------------
// ip_route_table
// IPv4 route table with first-match lookup, add and delete in insertion order.
// ----------------------------------------------------------------------------
// Each word passes through a compare state, in which every entry is compared
// in parallel against the address (or the gateway of an added route) and the
// exact destination, and a commit state, in which a priority pick chooses the
// entry, the packed table is updated and the result register is loaded. A new
// word is accepted in the commit state, so it overlaps only the commit of the
// previous word; a result that is not taken holds the block in its commit state.
// Reset clears all valid bits at once and needs no clearing pass.
`default_nettype none

module ip_route_table #(
    parameter int ROUTE_ENTRIES = rt_pkg::ROUTE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rt_pkg::in_word_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output rt_pkg::out_word_t     out_word
);
    import rt_pkg::*;

    rt_ctrl_t ctrl;

    // Sequencing.
    rt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    // Table and compare logic.
    rt_datapath #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_word  (in_word),
        .out_word (out_word)
    );

endmodule

`default_nettype wire

FILE: rtl/core/rt_checker.sv
// ----------------------------------------------------------------------------
// rt_checker
// Port-level checks of the route table, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rt_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire rt_pkg::in_word_t  in_word,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire rt_pkg::out_word_t out_word
);
    import rt_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.status == ST_OK) || (out_word.status == ST_UNREACH)
                      || (out_word.status == ST_FULL))
        else $error("undefined status code");

    // A failed word carries no next hop and no device.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status != ST_OK)
            |-> (out_word.next_hop == 32'd0) && (out_word.out_device == 4'd0))
        else $error("failed result carries a next hop or device");

    // After a word is accepted the block spends its compare cycle busy.
    a_compare_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted during compare cycle");

    // The result is visible once the compare and commit cycles have passed,
    // or an older result is still waiting in the result register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##2 out_valid)
        else $error("result missing after accepted word");

endmodule

bind ip_route_table rt_checker u_rt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

`default_nettype wire
